// ===== rtl/assert_macros.svh =====
// Assertion macros used by channel_occupancy_survey, the top level of the channel survey block.
// Depends on nothing; each macro expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== rtl/cos_pkg.sv =====
// Types, codes and helper functions for the channel occupancy survey.
// Depends on nothing; imported by channel_occupancy_survey.
`default_nettype none

package cos_pkg;

   // Fixed field widths.
   localparam int CHAN_W  = 4;
   localparam int RSSI_W  = 8;
   localparam int WORD_W  = 32;
   localparam int SCORE_W = 7;
   localparam int AP_W    = 8;
   localparam int REQ_W   = 3;
   // Width for comparing channel numbers against slot bounds (slots stay below 256).
   localparam int CMP_W   = 8;

   localparam logic [CHAN_W-1:0]  REGION_RESET = 4'd13;
   localparam logic [SCORE_W-1:0] SCORE_CAP    = 7'd100;
   localparam logic [7:0]         SCORE_CAP_W  = 8'd100;
   localparam logic [7:0]         AP_WEIGHT    = 8'd12;
   localparam logic [AP_W-1:0]    AP_MAX       = 8'd255;
   // Above this many access points the score is capped regardless of frames.
   localparam logic [AP_W-1:0]    AP_CAP_LIMIT = 8'd8;

   typedef enum logic [REQ_W-1:0] {
      REQ_FRAME    = 3'd0,
      REQ_AP       = 3'd1,
      REQ_DWELL    = 3'd2,
      REQ_QUERY    = 3'd3,
      REQ_QUIETEST = 3'd4,
      REQ_CLEAR    = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_REPORT
   } state_type;

   // One table entry per channel slot.
   typedef struct packed {
      logic [WORD_W-1:0]        frames;
      logic signed [RSSI_W-1:0] peak;
      logic [AP_W-1:0]          aps;
      logic [WORD_W-1:0]        dwell;
   } entry_type;

   localparam entry_type ENTRY_RESET = '{frames: 32'd0, peak: 8'sh80, aps: 8'd0, dwell: 32'd0};

   // Busyness score: 12 per access point plus frames / 8, capped at 100.
   function automatic logic [SCORE_W-1:0] entry_score(input entry_type e);
      logic [WORD_W-4:0] frames_div;
      logic [7:0]        sum;
      frames_div = e.frames[WORD_W-1:3];
      sum = 8'(e.aps[3:0]) * AP_WEIGHT + {1'b0, frames_div[6:0]};
      if ((e.aps > AP_CAP_LIMIT) || (frames_div > 29'(SCORE_CAP))) begin
         return SCORE_CAP;
      end else if (sum > SCORE_CAP_W) begin
         return SCORE_CAP;
      end else begin
         return sum[SCORE_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/channel_occupancy_survey.sv =====
// Top level of the channel occupancy survey: per-channel table in one memory.
// Depends on cos_pkg and assert_macros.svh.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_*         taken when start is high and busy low
//   response  rsp_valid, rsp_*           one-cycle strobe, cannot be held off
//   config    csr_valid, csr_ready, csr_data   written when valid and ready
//
// Note, frame, access point, dwell and query transactions are a table read, then the
// write-back or report. A quietest search makes one pipelined read per channel scanned,
// then a read of the winner. Clear, unused codes and requests on invalid channels are
// handled when accepted and leave the block idle. Reset and clear mark every entry
// unwritten at once; no clearing pass runs.
// Responses never stall, and configuration is always ready.
`default_nettype none

`include "assert_macros.svh"

module channel_occupancy_survey #(
   parameter int CHAN_LOW  = 1,
   parameter int CHAN_HIGH = 14,
   parameter int SLOTS     = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [cos_pkg::REQ_W-1:0]           req_type,
   input  wire logic [cos_pkg::CHAN_W-1:0]          req_channel,
   input  wire logic signed [cos_pkg::RSSI_W-1:0]   req_rssi,
   input  wire logic [cos_pkg::WORD_W-1:0]          req_dwell_add,
   input  wire logic [cos_pkg::WORD_W-1:0]          req_min_dwell,
   output      logic                                rsp_valid,
   output      logic [cos_pkg::SCORE_W-1:0]         rsp_score,
   output      logic [cos_pkg::CHAN_W-1:0]          rsp_quietest_channel,
   output      logic signed [cos_pkg::RSSI_W-1:0]   rsp_peak_level,
   output      logic [cos_pkg::WORD_W-1:0]          rsp_frame_total,
   output      logic [cos_pkg::AP_W-1:0]            rsp_ap_total,
   output      logic [cos_pkg::WORD_W-1:0]          rsp_dwell_total,
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [cos_pkg::CHAN_W-1:0]          csr_data
);
   import cos_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int SCW = CHAN_W + 1;
   localparam logic [CMP_W-1:0] LOW_C   = CMP_W'(CHAN_LOW);
   localparam logic [CMP_W-1:0] HIGH_C  = CMP_W'(CHAN_HIGH);
   localparam logic [CMP_W-1:0] SLOTS_C = CMP_W'(SLOTS);

   // Table memory and per-entry written flags.
   entry_type        mem [SLOTS];
   entry_type        rd_data_ff;
   logic             rd_valid_ff;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             wr_en;
   entry_type        wr_data;
   entry_type        rd_entry;

   // Control and latched request.
   state_type                state_ff, state_in;
   req_code_type             op_ff, op_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic signed [RSSI_W-1:0] rssi_ff, rssi_in;
   logic [WORD_W-1:0]        add_ff, add_in;
   logic [WORD_W-1:0]        min_ff, min_in;
   logic [CHAN_W-1:0]        region_ff, region_in;

   // Scan pipeline.
   logic [SCW-1:0]     scan_c_ff, scan_c_in;
   logic               pend_ff, pend_in;
   logic [CHAN_W-1:0]  pend_c_ff, pend_c_in;
   logic [CHAN_W-1:0]  best_ff, best_in;
   logic [SCORE_W-1:0] low_score_ff, low_score_in;

   // Response registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]       rsp_score_ff, rsp_score_in;
   logic [CHAN_W-1:0]        rsp_best_ff, rsp_best_in;
   entry_type                rsp_entry_ff, rsp_entry_in;

   logic               req_chan_ok;
   logic               scan_more;
   logic [CMP_W-1:0]   scan_ext;
   logic [SCORE_W-1:0] rd_score;
   logic               accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rd_entry  = rd_valid_ff ? rd_data_ff : ENTRY_RESET;
   assign rd_score  = entry_score(rd_entry);

   // Channel range checks for the request and the scan counter.
   assign req_chan_ok = (CMP_W'(req_channel) >= LOW_C) && (CMP_W'(req_channel) <= HIGH_C)
                        && (CMP_W'(req_channel) < SLOTS_C);
   assign scan_ext  = CMP_W'(scan_c_ff);
   assign scan_more = (scan_ext <= CMP_W'(region_ff)) && (scan_ext >= LOW_C)
                      && (scan_ext <= HIGH_C) && (scan_ext < SLOTS_C);

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         region_ff    <= REGION_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         region_ff    <= region_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      rssi_ff       <= rssi_in;
      add_ff        <= add_in;
      min_ff        <= min_in;
      scan_c_ff     <= scan_c_in;
      pend_c_ff     <= pend_c_in;
      best_ff       <= best_in;
      low_score_ff  <= low_score_in;
      rsp_score_ff  <= rsp_score_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   // Next state, memory control and response.
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      region_in     = region_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      rssi_in       = rssi_ff;
      add_in        = add_ff;
      min_in        = min_ff;
      scan_c_in     = scan_c_ff;
      pend_in       = 1'b0;
      pend_c_in     = pend_c_ff;
      best_in       = best_ff;
      low_score_in  = low_score_ff;
      rsp_valid_in  = 1'b0;
      rsp_score_in  = rsp_score_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_entry_in  = rsp_entry_ff;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_entry;

      if (csr_valid && csr_ready) begin
         region_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_code_type'(req_type);
               addr_in = AW'(req_channel);
               rssi_in = req_rssi;
               add_in  = req_dwell_add;
               min_in  = req_min_dwell;
               rd_addr = AW'(req_channel);
               unique case (req_type)
                  REQ_FRAME, REQ_AP, REQ_DWELL, REQ_QUERY: begin
                     if (req_chan_ok) begin
                        state_in = ST_EXEC;
                     end
                  end
                  REQ_QUIETEST: begin
                     scan_c_in     = SCW'(CHAN_LOW);
                     best_in       = '0;
                     low_score_in  = '0;
                     state_in      = ST_SCAN;
                  end
                  REQ_CLEAR: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EXEC: begin
            state_in = ST_IDLE;
            case (op_ff)
               REQ_FRAME: begin
                  wr_en = 1'b1;
                  if (rd_entry.frames != '1) begin
                     wr_data.frames = rd_entry.frames + 1'b1;
                  end
                  if (rssi_ff > rd_entry.peak) begin
                     wr_data.peak = rssi_ff;
                  end
               end
               REQ_AP: begin
                  wr_en = 1'b1;
                  if (rd_entry.aps != AP_MAX) begin
                     wr_data.aps = rd_entry.aps + 1'b1;
                  end
               end
               REQ_DWELL: begin
                  wr_en = 1'b1;
                  wr_data.dwell = rd_entry.dwell + add_ff;
               end
               default: begin
                  // Query: report the entry as read.
                  rsp_valid_in = 1'b1;
                  rsp_score_in = rd_score;
                  rsp_best_in  = '0;
                  rsp_entry_in = rd_entry;
               end
            endcase
            if (wr_en) begin
               valid_in[addr_ff] = 1'b1;
            end
         end

         ST_SCAN: begin
            // Evaluate the entry read in the previous cycle.
            if (pend_ff && (rd_entry.dwell >= min_ff)) begin
               if ((best_ff == '0) || (rd_score < low_score_ff)) begin
                  best_in       = pend_c_ff;
                  low_score_in  = rd_score;
               end
            end
            // Issue the read of the next channel, or fetch the winner.
            if (scan_more) begin
               rd_addr   = AW'(scan_c_ff);
               pend_in   = 1'b1;
               pend_c_in = scan_c_ff[CHAN_W-1:0];
               scan_c_in = scan_c_ff + 1'b1;
            end else if (!pend_ff) begin
               rd_addr  = AW'(best_ff);
               state_in = ST_REPORT;
            end
         end

         ST_REPORT: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_score_in = low_score_ff;
            rsp_best_in  = best_ff;
            rsp_entry_in = (best_ff != '0) ? rd_entry : ENTRY_RESET;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_score            = rsp_score_ff;
   assign rsp_quietest_channel = rsp_best_ff;
   assign rsp_peak_level       = rsp_entry_ff.peak;
   assign rsp_frame_total      = rsp_entry_ff.frames;
   assign rsp_ap_total         = rsp_entry_ff.aps;
   assign rsp_dwell_total      = rsp_entry_ff.dwell;

   // A response only follows an execute or report cycle.
   `ASSERT_SAME(a_rsp_source, rsp_valid, $past(busy) && ($past(state_ff) != ST_SCAN))
   // Table writes happen only in the execute cycle of a transaction.
   `ASSERT_SAME(a_write_in_exec, wr_en, state_ff == ST_EXEC)
   // A pending scan read is only evaluated while scanning.
   `ASSERT_SAME(a_pend_in_scan, pend_ff, state_ff == ST_SCAN)
   // An accepted quietest search makes the block busy in the next cycle.
   `ASSERT_NEXT(a_busy_after_accept, accept && (req_type == REQ_QUIETEST), busy)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the channel occupancy survey block.
// Depends on cos_pkg and channel_occupancy_survey from the RTL; it keeps its own
// copy of the channel table, predicts every report and compares it field by field.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cos_pkg::*;

   localparam int CHAN_FIRST    = 1;
   localparam int CHAN_LAST     = 14;
   localparam int SLOT_COUNT    = 16;
   // Spare request codes that the block must ignore.
   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
   // Margin left after the last report, enough for a quietest search over all channels.
   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int GENERAL_ITEMS = 160;
   localparam int HAMMER_ITEMS  = 600;
   localparam int PHASES        = 7;

   // One request transaction as presented on the req_ ports.
   typedef struct {
      logic [REQ_W-1:0]         kind;
      logic [CHAN_W-1:0]        chan;
      logic signed [RSSI_W-1:0] rssi;
      logic [WORD_W-1:0]        dwell_add;
      logic [WORD_W-1:0]        min_dwell;
   } survey_req_type;

   // One report transaction as seen on the rsp_ ports.
   typedef struct {
      logic [SCORE_W-1:0]       score;
      logic [CHAN_W-1:0]        quiet_ch;
      logic signed [RSSI_W-1:0] peak;
      logic [WORD_W-1:0]        frames;
      logic [AP_W-1:0]          aps;
      logic [WORD_W-1:0]        dwell;
   } survey_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [REQ_W-1:0]         req_type = '0;
   logic [CHAN_W-1:0]        req_channel = '0;
   logic signed [RSSI_W-1:0] req_rssi = '0;
   logic [WORD_W-1:0]        req_dwell_add = '0;
   logic [WORD_W-1:0]        req_min_dwell = '0;
   logic                     rsp_valid;
   logic [SCORE_W-1:0]       rsp_score;
   logic [CHAN_W-1:0]        rsp_quietest_channel;
   logic signed [RSSI_W-1:0] rsp_peak_level;
   logic [WORD_W-1:0]        rsp_frame_total;
   logic [AP_W-1:0]          rsp_ap_total;
   logic [WORD_W-1:0]        rsp_dwell_total;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CHAN_W-1:0]        csr_data = '0;

   // Predicted table contents and register.
   logic [WORD_W-1:0]        tbl_frames [SLOT_COUNT];
   logic signed [RSSI_W-1:0] tbl_peak   [SLOT_COUNT];
   logic [AP_W-1:0]          tbl_aps    [SLOT_COUNT];
   logic [WORD_W-1:0]        tbl_dwell  [SLOT_COUNT];
   logic [CHAN_W-1:0]        region_limit;

   survey_req_type    pending_requests[$];
   survey_report_type expected_reports[$];
   survey_req_type    in_flight;
   survey_report_type report_due;

   int unsigned idle_pct = 0;
   int unsigned stall_cycles = 0;
   int unsigned error_count = 0;
   int unsigned requests_done = 0;
   int unsigned reports_checked = 0;
   int unsigned region_writes = 0;

   channel_occupancy_survey #(
      .CHAN_LOW  (CHAN_FIRST),
      .CHAN_HIGH (CHAN_LAST),
      .SLOTS     (SLOT_COUNT)
   ) uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_channel          (req_channel),
      .req_rssi             (req_rssi),
      .req_dwell_add        (req_dwell_add),
      .req_min_dwell        (req_min_dwell),
      .rsp_valid            (rsp_valid),
      .rsp_score            (rsp_score),
      .rsp_quietest_channel (rsp_quietest_channel),
      .rsp_peak_level       (rsp_peak_level),
      .rsp_frame_total      (rsp_frame_total),
      .rsp_ap_total         (rsp_ap_total),
      .rsp_dwell_total      (rsp_dwell_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   always #1 clock = ~clock;

   // Channel table model.

   function automatic bit chan_ok(input int unsigned ch);
      return ch >= CHAN_FIRST && ch <= CHAN_LAST && ch < SLOT_COUNT;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         tbl_frames[i] = '0;
         tbl_peak[i]   = -8'sd128;
         tbl_aps[i]    = '0;
         tbl_dwell[i]  = '0;
      end
   endfunction

   // Busyness: 12 per access point plus frames / 8, capped at 100.
   function automatic logic [SCORE_W-1:0] busyness(input int unsigned ch);
      longint unsigned raw;
      raw = 64'(tbl_aps[ch]) * 64'(AP_WEIGHT) + 64'(tbl_frames[ch] >> 3);
      return (raw > 64'(SCORE_CAP)) ? SCORE_CAP : raw[SCORE_W-1:0];
   endfunction

   function automatic survey_report_type channel_report(input int unsigned ch,
                                                        input logic [SCORE_W-1:0] score,
                                                        input logic [CHAN_W-1:0] quiet_ch);
      survey_report_type r;
      r.score    = score;
      r.quiet_ch = quiet_ch;
      r.peak     = tbl_peak[ch];
      r.frames   = tbl_frames[ch];
      r.aps      = tbl_aps[ch];
      r.dwell    = tbl_dwell[ch];
      return r;
   endfunction

   // Update the model for one accepted request and queue any report it causes.
   function automatic void apply_request(input survey_req_type q);
      int unsigned        c;
      int unsigned        best;
      logic [SCORE_W-1:0] low_score;
      logic [SCORE_W-1:0] s;
      survey_report_type  r;
      case (q.kind)
         REQ_FRAME: begin
            if (chan_ok(32'(q.chan))) begin
               if (tbl_frames[q.chan] != '1) tbl_frames[q.chan]++;
               if (q.rssi > tbl_peak[q.chan]) tbl_peak[q.chan] = q.rssi;
            end
         end
         REQ_AP: begin
            if (chan_ok(32'(q.chan)) && tbl_aps[q.chan] != AP_MAX) tbl_aps[q.chan]++;
         end
         REQ_DWELL: begin
            if (chan_ok(32'(q.chan))) tbl_dwell[q.chan] = tbl_dwell[q.chan] + q.dwell_add;
         end
         REQ_QUERY: begin
            if (chan_ok(32'(q.chan))) begin
               expected_reports.push_back(channel_report(32'(q.chan),
                                                         busyness(32'(q.chan)), '0));
            end
         end
         REQ_QUIETEST: begin
            best = 0;
            low_score = '0;
            // Scan up to the region limit; ties keep the lowest channel number.
            for (c = CHAN_FIRST; c <= 32'(region_limit) && chan_ok(c); c++) begin
               if (tbl_dwell[c] >= q.min_dwell) begin
                  s = busyness(c);
                  if (best == 0 || s < low_score) begin
                     best = c;
                     low_score = s;
                  end
               end
            end
            if (best != 0) begin
               r = channel_report(best, low_score, CHAN_W'(best));
            end else begin
               r = '{score: '0, quiet_ch: '0, peak: -8'sd128, frames: '0, aps: '0,
                     dwell: '0};
            end
            expected_reports.push_back(r);
         end
         REQ_CLEAR: wipe_table();
         default: ;
      endcase
   endfunction

   // Stimulus generation.

   function automatic survey_req_type make_req(input logic [REQ_W-1:0] kind,
                                               input logic [CHAN_W-1:0] chan,
                                               input logic signed [RSSI_W-1:0] rssi,
                                               input logic [WORD_W-1:0] dwell_add,
                                               input logic [WORD_W-1:0] min_dwell);
      survey_req_type q;
      q.kind = kind;
      q.chan = chan;
      q.rssi = rssi;
      q.dwell_add = dwell_add;
      q.min_dwell = min_dwell;
      return q;
   endfunction

   function automatic survey_req_type random_request();
      survey_req_type q;
      int unsigned pick;
      q.rssi = RSSI_W'($urandom);
      pick = $urandom_range(9);
      if (pick < 5)      q.dwell_add = $urandom_range(200);
      else if (pick < 8) q.dwell_add = $urandom;
      else               q.dwell_add = $urandom_range(1) ? '1 : '0;
      pick = $urandom_range(9);
      if (pick < 2)      q.min_dwell = '0;
      else if (pick < 6) q.min_dwell = $urandom_range(400);
      else if (pick < 8) q.min_dwell = $urandom;
      else               q.min_dwell = '1;
      // Mostly valid channels, with the out-of-range ones now and then.
      if ($urandom_range(99) < 12) q.chan = CHAN_W'($urandom_range(15));
      else                         q.chan = CHAN_W'($urandom_range(CHAN_LAST, CHAN_FIRST));
      pick = $urandom_range(99);
      if (pick < 34)      q.kind = REQ_FRAME;
      else if (pick < 46) q.kind = REQ_AP;
      else if (pick < 64) q.kind = REQ_DWELL;
      else if (pick < 82) q.kind = REQ_QUERY;
      else if (pick < 97) q.kind = REQ_QUIETEST;
      else if (pick < 98) q.kind = REQ_CLEAR;
      else                q.kind = $urandom_range(1) ? REQ_SPARE_LO : REQ_SPARE_HI;
      return q;
   endfunction

   // Heavy traffic on two channels, to reach access point saturation and the
   // frame-driven score cap.
   function automatic survey_req_type hammer_request(input logic [CHAN_W-1:0] ap_chan,
                                                     input logic [CHAN_W-1:0] frame_chan);
      survey_req_type q;
      int unsigned pick;
      q = random_request();
      pick = $urandom_range(99);
      if (pick < 25) begin
         q.kind = REQ_AP;
         q.chan = ap_chan;
      end else if (pick < 94) begin
         q.kind = REQ_FRAME;
         q.chan = frame_chan;
      end else if (pick < 98) begin
         q.kind = REQ_QUERY;
         q.chan = pick[0] ? ap_chan : frame_chan;
      end else begin
         q.kind = REQ_QUIETEST;
      end
      return q;
   endfunction

   // Request driver: presents queued transactions, holds them while busy.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_request(in_flight);
            requests_done++;
         end
         if (!(start && busy)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               in_flight = pending_requests.pop_front();
               start         <= 1'b1;
               req_type      <= in_flight.kind;
               req_channel   <= in_flight.chan;
               req_rssi      <= in_flight.rssi;
               req_dwell_add <= in_flight.dwell_add;
               req_min_dwell <= in_flight.min_dwell;
            end else begin
               // Idle cycle: the fields carry noise that the block must ignore.
               start         <= 1'b0;
               req_type      <= REQ_W'($urandom);
               req_channel   <= CHAN_W'($urandom);
               req_rssi      <= RSSI_W'($urandom);
               req_dwell_add <= $urandom;
               req_min_dwell <= $urandom;
            end
         end
      end
   end

   task automatic check_field(input string label, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         error_count++;
      end
   endtask

   // Report monitor: every strobe is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: report with none expected, score %0h channel %0h", $time,
                     rsp_score, rsp_quietest_channel);
            error_count++;
         end else begin
            report_due = expected_reports.pop_front();
            check_field("score", WORD_W'(report_due.score), WORD_W'(rsp_score));
            check_field("quietest_channel", WORD_W'(report_due.quiet_ch),
                        WORD_W'(rsp_quietest_channel));
            check_field("peak_level", WORD_W'(report_due.peak), WORD_W'(rsp_peak_level));
            check_field("frame_total", report_due.frames, rsp_frame_total);
            check_field("ap_total", WORD_W'(report_due.aps), WORD_W'(rsp_ap_total));
            check_field("dwell_total", report_due.dwell, rsp_dwell_total);
            reports_checked++;
         end
      end
   end

   // Count cycles without any transaction on any channel.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Wait until every request is taken and every report has come back.
   task automatic wait_until_quiet();
      while (pending_requests.size() > 0 || start || expected_reports.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_region(input logic [CHAN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      region_limit = value;
      region_writes++;
   endtask

   // Phase sequencing: directed checks first, then random phases, each with
   // its own region limit and idle level.
   initial begin
      logic [CHAN_W-1:0] region_plan [PHASES];
      int unsigned       idle_plan [PHASES];
      bit                hammer_plan [PHASES];
      logic [CHAN_W-1:0] ap_chan;
      logic [CHAN_W-1:0] frame_chan;
      int unsigned       n;

      region_plan = '{4'd14, 4'd0, 4'd15, 4'd1, 4'd14, 4'd13, CHAN_W'($urandom)};
      idle_plan   = '{84, 0, 37, 0, 84, 37, 0};
      hammer_plan = '{0, 0, 0, 1, 1, 0, 0};
      ap_chan     = CHAN_W'($urandom_range(CHAN_LAST, CHAN_FIRST));
      frame_chan  = (ap_chan == CHAN_LAST) ? CHAN_W'(CHAN_FIRST) : ap_chan + 1'b1;

      wipe_table();
      region_limit = REGION_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the region limit left by reset.
      idle_pct = 0;
      pending_requests.push_back(make_req(REQ_QUERY, 4'd1, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUIETEST, 4'd5, 0, 0, 32'd0));
      pending_requests.push_back(make_req(REQ_QUIETEST, 4'd5, 0, 0, 32'd1));
      pending_requests.push_back(make_req(REQ_FRAME, 4'd1, -8'sd128, 0, 0));
      pending_requests.push_back(make_req(REQ_FRAME, 4'd1, 8'sd127, 0, 0));
      pending_requests.push_back(make_req(REQ_FRAME, 4'd14, -8'sd1, 0, 0));
      pending_requests.push_back(make_req(REQ_FRAME, 4'd0, 8'sd50, 0, 0));
      pending_requests.push_back(make_req(REQ_FRAME, 4'd15, 8'sd50, 0, 0));
      pending_requests.push_back(make_req(REQ_AP, 4'd14, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_AP, 4'd0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_DWELL, 4'd1, 0, 32'hFFFF_FFFF, 0));
      pending_requests.push_back(make_req(REQ_DWELL, 4'd1, 0, 32'd2, 0));
      pending_requests.push_back(make_req(REQ_DWELL, 4'd14, 0, 32'hFFFF_FFFF, 0));
      pending_requests.push_back(make_req(REQ_DWELL, 4'd13, 0, 32'd5, 0));
      pending_requests.push_back(make_req(REQ_DWELL, 4'd15, 0, 32'd7, 0));
      pending_requests.push_back(make_req(REQ_QUERY, 4'd1, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUERY, 4'd14, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUERY, 4'd0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUERY, 4'd15, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUIETEST, 4'd0, 0, 0, 32'd1));
      // Only channel 14 holds the full dwell, and it lies above the limit.
      pending_requests.push_back(make_req(REQ_QUIETEST, 4'd0, 0, 0, 32'hFFFF_FFFF));
      pending_requests.push_back(make_req(REQ_SPARE_LO, 4'd1, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_SPARE_HI, 4'd1, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_CLEAR, 4'd0, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUERY, 4'd1, 0, 0, 0));
      pending_requests.push_back(make_req(REQ_QUIETEST, 4'd0, 0, 0, 32'd0));
      wait_until_quiet();

      // Random phases.
      for (int p = 0; p < PHASES; p++) begin
         write_region(region_plan[p]);
         idle_pct = idle_plan[p];
         n = hammer_plan[p] ? HAMMER_ITEMS : GENERAL_ITEMS;
         for (int i = 0; i < n; i++) begin
            if (hammer_plan[p]) pending_requests.push_back(hammer_request(ap_chan, frame_chan));
            else                pending_requests.push_back(random_request());
         end
         wait_until_quiet();
      end

      $display("Ran %0d request transactions and checked %0d reports.", requests_done,
               reports_checked);
      $display("Region limit written %0d times, idle levels 0, 37 and 84 percent.",
               region_writes);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== channel_occupancy_survey.f =====
+incdir+rtl
rtl/cos_pkg.sv
rtl/channel_occupancy_survey.sv
sim/tb_top.sv
